// ----- design/ufpt_pkg.sv -----
`timescale 1ns / 1ps

package ufpt_pkg;

	localparam int CAPACITY = 256;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam int KEY_W   = 64;
	localparam int FLAGS_W = 32;
	localparam int GEN_W   = 31;
	localparam int FUNC_W  = 3;
	localparam int STAT_W  = 2;
	localparam int WORD_W  = 2 * KEY_W + FLAGS_W;

	localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
	localparam logic [GEN_W-1:0] GEN_WRAP = 31'd2147483646;
	localparam logic [GEN_W-1:0] GEN_INIT = 31'd1;

	localparam logic [FLAGS_W-1:0] CLEAR_DEFAULT_INIT = 32'd1;

	localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd0;
	localparam logic [FUNC_W-1:0] FN_ADD    = 3'd1;
	localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd2;
	localparam logic [FUNC_W-1:0] FN_LOOKUP = 3'd3;

	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_INVALID   = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [GEN_W-1:0]   gen_t;
	typedef logic [FLAGS_W-1:0] flags_t;
	typedef logic [KEY_W-1:0]   key_t;
	typedef logic [WORD_W-1:0]  word_t;

endpackage

// ----- design/uuid_flag_policy_table_unit.sv -----
`timescale 1ns / 1ps

// UUID flag policy table: up to CAPACITY entries keyed by a 128-bit UUID,
// each holding a 32-bit flag word, plus a table generation counter.
// Command channel: a command (func, key_high, key_low, flags_in,
// cached_generation) is taken at a clock edge with start high and busy low.
// Result channel: done is high for exactly one cycle with status, flags_out,
// generation_out and cache_still_valid; the receiver cannot stall it, and a
// new command may be started in the cycle that done is high.
// Config channel: cfg_data (clear default flags) is written when cfg_valid
// is high; cfg_ready is always high. Write it only while the table is idle.
// Invalid commands, a lookup whose cached generation is current and a clear
// of an empty table answer in the cycle after start. All other commands
// walk the entry memory one read per cycle; a key match in entry k answers
// once entry k has been read and compared, otherwise the answer comes after
// all CAPACITY entries have been read. The single read port of the entry
// memory sets this pace. A new command is not taken until the current one
// is answered; the next one is taken at the edge that ends the done cycle.
// Reset clears all valid marks, the entry count and sets the generation to 1
// and the clear default flags to 1; no clearing pass is needed.

module uuid_flag_policy_table_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [ufpt_pkg::FUNC_W-1:0] func,
	input  logic [ufpt_pkg::KEY_W-1:0]  key_high,
	input  logic [ufpt_pkg::KEY_W-1:0]  key_low,
	input  logic [ufpt_pkg::FLAGS_W-1:0] flags_in,
	input  logic [ufpt_pkg::GEN_W-1:0]  cached_generation,
	output logic                      done,
	output logic [ufpt_pkg::STAT_W-1:0] status,
	output logic [ufpt_pkg::FLAGS_W-1:0] flags_out,
	output logic [ufpt_pkg::GEN_W-1:0]  generation_out,
	output logic                      cache_still_valid,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [ufpt_pkg::FLAGS_W-1:0] cfg_data
);

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} state_t;

	state_t state_q;

	logic [ufpt_pkg::CAPACITY-1:0] valid_q;
	ufpt_pkg::cnt_t   cnt_q;
	ufpt_pkg::gen_t   gen_q;
	ufpt_pkg::flags_t cdf_q;
	ufpt_pkg::cnt_t   idx_q;
	logic             rd_vld_s1;
	ufpt_pkg::idx_t   idx_s1;
	logic             free_found_q;
	ufpt_pkg::idx_t   free_idx_q;

	logic [ufpt_pkg::FUNC_W-1:0] func_q;
	ufpt_pkg::key_t   kh_q;
	ufpt_pkg::key_t   kl_q;
	ufpt_pkg::flags_t f_q;
	ufpt_pkg::flags_t cf_q;

	logic [ufpt_pkg::STAT_W-1:0] status_q;
	ufpt_pkg::flags_t flags_out_q;
	ufpt_pkg::gen_t   gen_out_q;
	logic             still_q;
	logic             done_q;

	logic             accept;
	logic             in_null;
	logic             in_bad;
	ufpt_pkg::gen_t   gen_inc;

	logic             rd_en;
	ufpt_pkg::idx_t   raddr;
	ufpt_pkg::word_t  rdata;
	logic             we;
	ufpt_pkg::idx_t   waddr;
	ufpt_pkg::word_t  wdata;

	ufpt_pkg::key_t   ent_kh;
	ufpt_pkg::key_t   ent_kl;
	ufpt_pkg::flags_t ent_flags;
	logic             ent_valid;
	logic             hit;
	logic             scan_end;
	logic             clr_drop;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	assign done              = done_q;
	assign status            = status_q;
	assign flags_out         = flags_out_q;
	assign generation_out    = gen_out_q;
	assign cache_still_valid = still_q;

	assign in_null = (key_high == '0) && (key_low == '0);
	assign in_bad  = (func != ufpt_pkg::FN_CLEAR) && (func != ufpt_pkg::FN_ADD) &&
		(func != ufpt_pkg::FN_REMOVE) && (func != ufpt_pkg::FN_LOOKUP);

	assign gen_inc = (gen_q >= ufpt_pkg::GEN_WRAP) ? ufpt_pkg::GEN_INIT
		: gen_q + ufpt_pkg::GEN_INIT;

	ufpt_ram #(
		.WIDTH(ufpt_pkg::WORD_W),
		.DEPTH(ufpt_pkg::CAPACITY)
	) u_entry_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (rd_en),
		.raddr(raddr),
		.rdata(rdata)
	);

	// compare stage: entry idx_s1 is on rdata this cycle
	always_comb begin
		ent_kh    = rdata[ufpt_pkg::WORD_W-1 -: ufpt_pkg::KEY_W];
		ent_kl    = rdata[ufpt_pkg::FLAGS_W +: ufpt_pkg::KEY_W];
		ent_flags = rdata[ufpt_pkg::FLAGS_W-1:0];
		ent_valid = valid_q[idx_s1];
		hit       = rd_vld_s1 && ent_valid && (ent_kh == kh_q) && (ent_kl == kl_q);
		clr_drop  = rd_vld_s1 && ent_valid && ((ent_flags & ~cf_q) == '0);
		scan_end  = (state_q == S_SCAN) && !rd_vld_s1 && (idx_q == ufpt_pkg::CAP_CNT);
		rd_en     = (state_q == S_SCAN) && (idx_q != ufpt_pkg::CAP_CNT);
		raddr     = idx_q[ufpt_pkg::IDX_W-1:0];

		we    = 1'b0;
		waddr = idx_s1;
		wdata = {ent_kh, ent_kl, ent_flags};
		if (state_q == S_SCAN) begin
			unique case (func_q)
				ufpt_pkg::FN_CLEAR: begin
					if (rd_vld_s1 && ent_valid && !clr_drop) begin
						we    = 1'b1;
						wdata = {ent_kh, ent_kl, ent_flags & ~cf_q};
					end
				end
				ufpt_pkg::FN_ADD: begin
					if (hit) begin
						we    = 1'b1;
						wdata = {ent_kh, ent_kl, ent_flags | f_q};
					end else if (scan_end && (cnt_q < ufpt_pkg::CAP_CNT)) begin
						we    = 1'b1;
						waddr = free_idx_q;
						wdata = {kh_q, kl_q, f_q};
					end
				end
				ufpt_pkg::FN_REMOVE: begin
					if (hit && (ent_flags != f_q)) begin
						we    = 1'b1;
						wdata = {ent_kh, ent_kl, ent_flags & ~f_q};
					end
				end
				default: begin
				end
			endcase
		end
	end

	// command latch and scan bookkeeping, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			kh_q   <= key_high;
			kl_q   <= key_low;
			f_q    <= flags_in;
			cf_q   <= (flags_in == '0) ? cdf_q : flags_in;
		end
		idx_s1 <= idx_q[ufpt_pkg::IDX_W-1:0];
		if (state_q == S_SCAN && rd_vld_s1 && !ent_valid && !free_found_q) begin
			free_idx_q <= idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			cnt_q        <= '0;
			gen_q        <= ufpt_pkg::GEN_INIT;
			cdf_q        <= ufpt_pkg::CLEAR_DEFAULT_INIT;
			idx_q        <= '0;
			rd_vld_s1    <= 1'b0;
			free_found_q <= 1'b0;
			done_q       <= 1'b0;
			status_q     <= ufpt_pkg::ST_OK;
			flags_out_q  <= '0;
			gen_out_q    <= ufpt_pkg::GEN_INIT;
			still_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid) begin
				cdf_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						status_q    <= ufpt_pkg::ST_OK;
						flags_out_q <= '0;
						still_q     <= 1'b0;
						gen_out_q   <= gen_q;
						if (in_bad || (func != ufpt_pkg::FN_CLEAR && in_null)) begin
							done_q   <= 1'b1;
							status_q <= ufpt_pkg::ST_INVALID;
						end else if (func == ufpt_pkg::FN_LOOKUP &&
							cached_generation == gen_q) begin
							done_q  <= 1'b1;
							still_q <= 1'b1;
						end else if (func == ufpt_pkg::FN_CLEAR && cnt_q == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q      <= S_SCAN;
							idx_q        <= '0;
							rd_vld_s1    <= 1'b0;
							free_found_q <= 1'b0;
						end
					end
				end
				S_SCAN: begin
					idx_q     <= idx_q + ufpt_pkg::cnt_t'(rd_en);
					rd_vld_s1 <= rd_en;
					if (rd_vld_s1 && !ent_valid) begin
						free_found_q <= 1'b1;
					end
					unique case (func_q)
						ufpt_pkg::FN_CLEAR: begin
							if (clr_drop) begin
								valid_q[idx_s1] <= 1'b0;
								cnt_q           <= cnt_q - ufpt_pkg::cnt_t'(1);
							end
							if (scan_end) begin
								gen_q     <= gen_inc;
								gen_out_q <= gen_inc;
								done_q    <= 1'b1;
								state_q   <= S_IDLE;
							end
						end
						ufpt_pkg::FN_ADD: begin
							if (hit) begin
								gen_q     <= gen_inc;
								gen_out_q <= gen_inc;
								done_q    <= 1'b1;
								state_q   <= S_IDLE;
							end else if (scan_end) begin
								done_q  <= 1'b1;
								state_q <= S_IDLE;
								if (cnt_q < ufpt_pkg::CAP_CNT) begin
									valid_q[free_idx_q] <= 1'b1;
									cnt_q               <= cnt_q + ufpt_pkg::cnt_t'(1);
									gen_q               <= gen_inc;
									gen_out_q           <= gen_inc;
								end else begin
									status_q <= ufpt_pkg::ST_FULL;
								end
							end
						end
						ufpt_pkg::FN_REMOVE: begin
							if (hit) begin
								if (ent_flags == f_q) begin
									valid_q[idx_s1] <= 1'b0;
									cnt_q           <= cnt_q - ufpt_pkg::cnt_t'(1);
								end
								gen_q     <= gen_inc;
								gen_out_q <= gen_inc;
								done_q    <= 1'b1;
								state_q   <= S_IDLE;
							end else if (scan_end) begin
								status_q <= ufpt_pkg::ST_NOT_FOUND;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end
						end
						default: begin
							if (hit) begin
								flags_out_q <= ent_flags;
								done_q      <= 1'b1;
								state_q     <= S_IDLE;
							end else if (scan_end) begin
								status_q <= ufpt_pkg::ST_NOT_FOUND;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end
						end
					endcase
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cnt_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(cnt_q))
		else $error("entry count differs from number of valid entries");

	a_cnt_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= ufpt_pkg::CAP_CNT)
		else $error("entry count above capacity");

	a_gen_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(gen_q != '0) && (gen_q <= ufpt_pkg::GEN_WRAP))
		else $error("generation out of range");

	a_cached_no_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(done && cache_still_valid) |-> (flags_out == '0) && (status == ufpt_pkg::ST_OK))
		else $error("cached lookup returned flags or bad status");

	a_start_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted command neither answered nor in progress");
`endif

endmodule

// ----- design/ufpt_ram.sv -----
`timescale 1ns / 1ps

module ufpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- verif/uuid_flag_policy_table_unit_tb.sv -----
`timescale 1ns / 1ps

module uuid_flag_policy_table_unit_tb;
	import ufpt_pkg::*;

	localparam logic [FUNC_W-1:0] FN_LAST = 3'd7;
	localparam int POOL_SIZE       = 320;
	localparam int WATCHDOG_CYCLES = 20 * (CAPACITY + 2);
	localparam int SETTLE_CYCLES   = CAPACITY + 8;
	localparam int N_PHASES        = 7;
	localparam int FILL_PHASE      = 3;
	localparam int FILL_KEYS       = 300;

	typedef struct {
		logic [FUNC_W-1:0] fn;
		key_t              kh;
		key_t              kl;
		flags_t            fl;
		gen_t              cg;
		bit                live_gen;   // cached_generation taken from the table at issue
		bit                live_flags; // flags_in taken from the entry at issue
	} policy_cmd_t;

	typedef struct {
		logic [STAT_W-1:0] st;
		flags_t            fl;
		gen_t              gen;
		logic              csv;
	} policy_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [FUNC_W-1:0] func = '0;
	key_t key_high = '0;
	key_t key_low = '0;
	flags_t flags_in = '0;
	gen_t cached_generation = '0;
	logic done;
	logic [STAT_W-1:0] status;
	flags_t flags_out;
	gen_t generation_out;
	logic cache_still_valid;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	flags_t cfg_data = '0;

	// table shadow
	bit     tbl_valid [CAPACITY];
	key_t   tbl_kh [CAPACITY];
	key_t   tbl_kl [CAPACITY];
	flags_t tbl_flags [CAPACITY];
	int     tbl_count = 0;
	int     tbl_peak = 0;
	gen_t   tbl_gen = GEN_INIT;
	flags_t clear_dflt = CLEAR_DEFAULT_INIT;

	policy_cmd_t    pending_cmds [$];
	policy_result_t exp_results [$];
	key_t           pool_kh [POOL_SIZE];
	key_t           pool_kl [POOL_SIZE];

	bit no_gaps = 1'b0;
	int n_errors = 0;
	int n_cmds = 0;
	int n_results = 0;
	int n_cfg = 0;
	int n_cache_hits = 0;
	int st_seen [4] = '{0, 0, 0, 0};
	int idle_cycles = 0;

	uuid_flag_policy_table_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.key_high(key_high),
		.key_low(key_low),
		.flags_in(flags_in),
		.cached_generation(cached_generation),
		.done(done),
		.status(status),
		.flags_out(flags_out),
		.generation_out(generation_out),
		.cache_still_valid(cache_still_valid),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		n_errors++;
		if (n_errors <= 20)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s got %0h want %0h",
				n_results, name, got, want));
	endtask

	function automatic int find_entry(input key_t kh, input key_t kl);
		for (int i = 0; i < CAPACITY; i++)
			if (tbl_valid[i] && tbl_kh[i] == kh && tbl_kl[i] == kl)
				return i;
		return -1;
	endfunction

	function automatic void bump_gen();
		if (tbl_gen >= GEN_WRAP)
			tbl_gen = GEN_INIT;
		else
			tbl_gen = tbl_gen + 1'b1;
	endfunction

	// applies one command to the shadow table and queues the answer it must give
	function automatic void predict_policy_result(input policy_cmd_t c);
		policy_result_t r;
		flags_t cf;
		int slot;
		bit is_null;
		r.st = ST_OK;
		r.fl = '0;
		r.csv = 1'b0;
		is_null = (c.kh == '0) && (c.kl == '0);
		if (c.fn == FN_CLEAR) begin
			cf = (c.fl == '0) ? clear_dflt : c.fl;
			if (tbl_count > 0) begin
				for (int i = 0; i < CAPACITY; i++) begin
					if (!tbl_valid[i])
						continue;
					if ((tbl_flags[i] & cf) == tbl_flags[i]) begin
						tbl_valid[i] = 1'b0;
						tbl_count--;
					end else begin
						tbl_flags[i] &= ~cf;
					end
				end
				bump_gen();
			end
		end else if (c.fn > FN_LOOKUP || is_null) begin
			r.st = ST_INVALID;
		end else if (c.fn == FN_ADD) begin
			slot = find_entry(c.kh, c.kl);
			if (slot >= 0) begin
				tbl_flags[slot] |= c.fl;
				bump_gen();
			end else if (tbl_count < CAPACITY) begin
				slot = 0;
				while (tbl_valid[slot])
					slot++;
				tbl_valid[slot] = 1'b1;
				tbl_kh[slot] = c.kh;
				tbl_kl[slot] = c.kl;
				tbl_flags[slot] = c.fl;
				tbl_count++;
				if (tbl_count > tbl_peak)
					tbl_peak = tbl_count;
				bump_gen();
			end else begin
				r.st = ST_FULL;
			end
		end else if (c.fn == FN_REMOVE) begin
			slot = find_entry(c.kh, c.kl);
			if (slot >= 0) begin
				if (tbl_flags[slot] == c.fl) begin
					tbl_valid[slot] = 1'b0;
					tbl_count--;
				end else begin
					tbl_flags[slot] &= ~c.fl;
				end
				bump_gen();
			end else begin
				r.st = ST_NOT_FOUND;
			end
		end else begin
			if (c.cg == tbl_gen) begin
				r.csv = 1'b1;
			end else begin
				slot = find_entry(c.kh, c.kl);
				if (slot >= 0)
					r.fl = tbl_flags[slot];
				else
					r.st = ST_NOT_FOUND;
			end
		end
		r.gen = tbl_gen;
		exp_results.push_back(r);
	endfunction

	function automatic flags_t rand_flags();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		if (r < 15)
			return '1;
		if (r < 65)
			return flags_t'($urandom_range(0, 15));
		if (r < 80)
			return flags_t'(1) << $urandom_range(0, FLAGS_W - 1);
		return $urandom;
	endfunction

	function automatic gen_t rand_gen();
		int r;
		r = $urandom_range(0, 99);
		if (r < 20)
			return '0;
		if (r < 30)
			return GEN_WRAP;
		if (r < 40)
			return GEN_INIT;
		return gen_t'($urandom_range(0, GEN_WRAP));
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	function automatic policy_cmd_t random_cmd(input int key_span);
		policy_cmd_t c;
		int r;
		int k;
		r = $urandom_range(0, 99);
		if (r < 5)
			c.fn = FN_CLEAR;
		else if (r < 10)
			c.fn = FUNC_W'($urandom_range(FN_LOOKUP + 1, FN_LAST));
		else if (r < 45)
			c.fn = FN_ADD;
		else if (r < 65)
			c.fn = FN_REMOVE;
		else
			c.fn = FN_LOOKUP;
		k = $urandom_range(0, 99);
		if (k < 5) begin
			c.kh = '0;
			c.kl = '0;
		end else if (k < 8) begin
			c.kh = {$urandom, $urandom};
			c.kl = {$urandom, $urandom};
		end else begin
			k = $urandom_range(0, key_span - 1);
			c.kh = pool_kh[k];
			c.kl = pool_kl[k];
		end
		c.fl = rand_flags();
		c.cg = rand_gen();
		c.live_gen = (c.fn == FN_LOOKUP) && ($urandom_range(0, 99) < 40);
		c.live_flags = (c.fn == FN_REMOVE) && ($urandom_range(0, 99) < 40);
		return c;
	endfunction

	task automatic queue_cmd(input logic [FUNC_W-1:0] fn, input key_t kh, input key_t kl,
			input flags_t fl, input gen_t cg, input bit lg, input bit lf);
		policy_cmd_t c;
		c.fn = fn;
		c.kh = kh;
		c.kl = kl;
		c.fl = fl;
		c.cg = cg;
		c.live_gen = lg;
		c.live_flags = lf;
		pending_cmds.push_back(c);
	endtask

	task automatic wait_table_idle();
		do
			@(negedge clk);
		while (pending_cmds.size() != 0 || start || exp_results.size() != 0);
	endtask

	task automatic write_clear_default(input flags_t v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		clear_dflt = v;
		n_cfg++;
		cfg_valid <= 1'b0;
	endtask

	// command driver
	int gap_left = 0;
	policy_cmd_t cur_cmd;

	always @(posedge clk or negedge arst_n) begin : drv
		policy_cmd_t c;
		logic nxt;
		int slot;
		if (!arst_n) begin
			start <= 1'b0;
			gap_left = 0;
		end else begin
			nxt = start;
			if (start && !busy) begin
				predict_policy_result(cur_cmd);
				n_cmds++;
				nxt = 1'b0;
				gap_left = pick_gap();
			end
			if (!nxt) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_cmds.size() != 0) begin
					c = pending_cmds.pop_front();
					// shadow is current here: every earlier command has been applied
					if (c.live_gen)
						c.cg = tbl_gen;
					if (c.live_flags) begin
						slot = find_entry(c.kh, c.kl);
						if (slot >= 0)
							c.fl = tbl_flags[slot];
					end
					cur_cmd = c;
					func <= c.fn;
					key_high <= c.kh;
					key_low <= c.kl;
					flags_in <= c.fl;
					cached_generation <= c.cg;
					nxt = 1'b1;
				end
			end
			start <= nxt;
		end
	end

	// result monitor
	always @(posedge clk) begin : mon
		policy_result_t e;
		if (arst_n) begin
			if ($isunknown(done)) begin
				report_mismatch("done strobe is unknown");
			end else if (done) begin
				n_results++;
				if (exp_results.size() == 0) begin
					report_mismatch($sformatf("result %0d with no command outstanding",
						n_results));
				end else begin
					e = exp_results.pop_front();
					check_field("status", 64'(status), 64'(e.st));
					check_field("flags_out", 64'(flags_out), 64'(e.fl));
					check_field("generation_out", 64'(generation_out), 64'(e.gen));
					check_field("cache_still_valid", 64'(cache_still_valid), 64'(e.csv));
					st_seen[e.st]++;
					if (e.csv)
						n_cache_hits++;
				end
			end
		end
	end

	// stall watchdog: any accepted beat restarts the count
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("timeout: no beat for %0d cycles, %0d results outstanding",
				idle_cycles, exp_results.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin : stim
		flags_t cfg_list [N_PHASES];
		int j;
		int span;

		pool_kh[0] = '1;
		pool_kl[0] = '1;
		pool_kh[1] = '0;
		pool_kl[1] = 64'd1;
		pool_kh[2] = {1'b1, 63'd0};
		pool_kl[2] = '0;
		pool_kh[3] = '0;
		pool_kl[3] = '1;
		// index in key_low[31:16] keeps the random keys distinct
		for (int i = 4; i < POOL_SIZE; i++) begin
			pool_kh[i] = {$urandom, $urandom};
			pool_kl[i] = {$urandom, 16'(i), 16'($urandom)};
		end

		cfg_list[0] = '0;
		cfg_list[1] = '1;
		cfg_list[2] = 32'h3;
		cfg_list[3] = 32'h8000_0000;
		cfg_list[4] = $urandom;
		cfg_list[5] = CLEAR_DEFAULT_INIT;
		cfg_list[6] = flags_t'($urandom_range(0, 15));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty table, null keys, bad funcs, OR-in, exact and partial remove
		queue_cmd(FN_CLEAR, pool_kh[0], pool_kl[0], '0, '0, 0, 0);
		queue_cmd(FN_LOOKUP, pool_kh[0], pool_kl[0], '0, '0, 0, 0);
		queue_cmd(FN_LOOKUP, pool_kh[0], pool_kl[0], '0, '0, 1, 0);
		queue_cmd(FN_ADD, '0, '0, '1, '0, 0, 0);
		queue_cmd(FN_REMOVE, '0, '0, '1, '0, 0, 0);
		queue_cmd(FN_LOOKUP, '0, '0, '0, '0, 1, 0);
		for (int f = FN_LOOKUP + 1; f <= FN_LAST; f++)
			queue_cmd(FUNC_W'(f), pool_kh[0], pool_kl[0], $urandom, GEN_WRAP, 0, 0);
		queue_cmd(FN_ADD, pool_kh[0], pool_kl[0], '1, '0, 0, 0);
		queue_cmd(FN_ADD, pool_kh[1], pool_kl[1], '0, '0, 0, 0);
		queue_cmd(FN_ADD, pool_kh[2], pool_kl[2], 32'h1, '0, 0, 0);
		queue_cmd(FN_ADD, pool_kh[3], pool_kl[3], 32'h8000_0000, '1, 0, 0);
		queue_cmd(FN_ADD, pool_kh[0], pool_kl[0], 32'h5, '0, 0, 0);
		queue_cmd(FN_LOOKUP, pool_kh[1], pool_kl[1], '0, '0, 0, 0);
		queue_cmd(FN_LOOKUP, pool_kh[0], pool_kl[0], '0, GEN_WRAP, 0, 0);
		queue_cmd(FN_LOOKUP, pool_kh[0], pool_kl[0], '0, '0, 1, 0);
		queue_cmd(FN_REMOVE, pool_kh[2], pool_kl[2], 32'h1, '0, 0, 0);
		queue_cmd(FN_REMOVE, pool_kh[0], pool_kl[0], 32'hF, '0, 0, 0);
		queue_cmd(FN_REMOVE, pool_kh[2], pool_kl[2], 32'h1, '0, 0, 0);
		queue_cmd(FN_CLEAR, '0, '0, '0, '0, 0, 0);
		queue_cmd(FN_CLEAR, '1, '1, '1, '0, 0, 0);
		queue_cmd(FN_CLEAR, '0, '0, '1, '0, 0, 0);

		for (int p = 0; p < N_PHASES; p++) begin
			wait_table_idle();
			write_clear_default(cfg_list[p]);
			@(negedge clk);
			no_gaps = (p == 1 || p == 5);
			if (p == FILL_PHASE) begin
				// fill to capacity, then overflow, free one slot and refill it
				queue_cmd(FN_CLEAR, '0, '0, '1, rand_gen(), 0, 0);
				for (int i = 0; i < FILL_KEYS; i++) begin
					queue_cmd(FN_ADD, pool_kh[i], pool_kl[i], rand_flags(), rand_gen(), 0, 0);
					if (i % 4 == 3) begin
						j = $urandom_range(0, i);
						queue_cmd(FN_LOOKUP, pool_kh[j], pool_kl[j], rand_flags(), rand_gen(),
							$urandom_range(0, 1), 0);
					end
				end
				queue_cmd(FN_ADD, pool_kh[7], pool_kl[7], '1, '0, 0, 0);
				queue_cmd(FN_REMOVE, pool_kh[10], pool_kl[10], '0, '0, 0, 1);
				queue_cmd(FN_ADD, pool_kh[305], pool_kl[305], rand_flags(), '0, 0, 0);
				queue_cmd(FN_ADD, pool_kh[306], pool_kl[306], rand_flags(), '0, 0, 0);
				queue_cmd(FN_LOOKUP, pool_kh[FILL_KEYS - 1], pool_kl[FILL_KEYS - 1], '0, '0,
					0, 0);
				queue_cmd(FN_CLEAR, '0, '0, '0, '0, 0, 0);
				repeat (40)
					pending_cmds.push_back(random_cmd(40));
			end else begin
				span = (p % 2) ? 40 : 12;
				repeat (160)
					pending_cmds.push_back(random_cmd(span));
			end
		end

		wait_table_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (exp_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", exp_results.size()));
		$display("%0d commands, %0d results: ok %0d, invalid %0d, not found %0d, full %0d",
			n_cmds, n_results, st_seen[ST_OK], st_seen[ST_INVALID], st_seen[ST_NOT_FOUND],
			st_seen[ST_FULL]);
		$display("cache-current lookups %0d, peak fill %0d of %0d, %0d clear-default writes",
			n_cache_hits, tbl_peak, CAPACITY, n_cfg);
		if (n_errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
